>>> hdl/w3rc_pkg.sv
// ----------------------------------------------------------------------------
// w3rc_pkg
// Shared types, widths and constants of the weighted 3x3 RGB convolution.
// ----------------------------------------------------------------------------
package w3rc_pkg;

  // Field and register widths
  localparam int unsigned KERNEL_W = 36;
  localparam int unsigned IMG_W_W  = 11;
  localparam int unsigned IMG_H_W  = 13;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned PIX_W    = 3 * CH_W;
  localparam int unsigned WT_W     = 4;
  localparam int unsigned SUM_W    = 16;  // 255 * 15 * 9 fits
  localparam int unsigned WSUM_W   = 8;   // 15 * 9 fits
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TAP_W    = 4;

  // Default limits
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  // Register reset values
  localparam logic [KERNEL_W-1:0] KERNEL_RST = 36'h100010000;
  localparam logic [IMG_W_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [IMG_H_W-1:0]  HEIGHT_RST = 13'd1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Tap sequencing
  localparam logic [TAP_W-1:0] TAP_LAST = 4'd8;
  localparam logic [TAP_W-1:0] TAP_DONE = 4'd9;

  // Row and column position codes of a tap
  localparam logic [1:0] POS_BEFORE = 2'd0;
  localparam logic [1:0] POS_CENTRE = 2'd1;
  localparam logic [1:0] POS_AFTER  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_e;

  // Row code of tap t (raster order over the 3x3 window)
  function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd1, 4'd2: r = POS_BEFORE;
      4'd3, 4'd4, 4'd5: r = POS_CENTRE;
      default:          r = POS_AFTER;
    endcase
    return r;
  endfunction

  // Column code of tap t
  function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] t);
    logic [1:0] c;
    case (t)
      4'd0, 4'd3, 4'd6: c = POS_BEFORE;
      4'd1, 4'd4, 4'd7: c = POS_CENTRE;
      default:          c = POS_AFTER;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/w3rc_linebuf.sv
// ----------------------------------------------------------------------------
// w3rc_linebuf
// Pixel history memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module w3rc_linebuf
  import w3rc_pkg::*;
#(
  parameter int unsigned DEPTH = 2 * DEF_MAX_WIDTH + 4,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [PIX_W-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [PIX_W-1:0] rdata_o
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  // Store incoming pixel
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one entry a cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/w3rc_div.sv
// ----------------------------------------------------------------------------
// w3rc_div
// Restoring divider, one quotient bit a cycle, truncating quotient.
// ----------------------------------------------------------------------------
module w3rc_div
  import w3rc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [WSUM_W-1:0] divisor_i,
  output logic              done_o,
  output logic [CH_W-1:0]   quot_o
);

  localparam int unsigned CW = $clog2(SUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [WSUM_W:0]   rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [WSUM_W-1:0] dvs_q, dvs_d;
  logic [WSUM_W:0]   trial;
  logic              fits;

  // One shift and trial subtract a cycle
  always_comb begin
    trial  = {rem_q[WSUM_W-1:0], quo_q[SUM_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, dvs_q}) : trial;
      quo_d = {quo_q[SUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath needs no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q[CH_W-1:0];

endmodule

>>> hdl/weighted_3x3_rgb_convolution.sv
// ----------------------------------------------------------------------------
// weighted_3x3_rgb_convolution
// Normalised 3x3 weighted average over an RGB raster stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and each output pixel is the truncated
// weighted mean of its 3x3 neighbourhood, counting only in-image taps with a
// nonzero weight; with no such tap the output is 0 and no_weight is set. The
// block handles one item at a time. An item that causes no result leaves the
// block ready for the next item in the following cycle. For one with a result,
// the nine taps are read from the history memory, one tap a cycle, the last
// read data is registered and accumulated, and the three bit-serial dividers
// are started and run their 16 steps before the result is offered. The history
// memory holds 2*MAX_WIDTH+4 pixels and needs no clearing pass. Flush items
// (command = 1) drain the outputs pending after the last pixel of a frame.
// Writing the frame width or frame height register restarts the frame.
// ----------------------------------------------------------------------------
module weighted_3x3_rgb_convolution
  import w3rc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KERNEL_W-1:0]  cfg_data_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [CH_W-1:0]      pixel_red_i,
  input  logic [CH_W-1:0]      pixel_green_i,
  input  logic [CH_W-1:0]      pixel_blue_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CH_W-1:0]      out_red_o,
  output logic [CH_W-1:0]      out_green_o,
  output logic [CH_W-1:0]      out_blue_o,
  output logic                 no_weight_o,
  output logic                 frame_end_o
);

  localparam int unsigned DEPTH = 2 * MAX_WIDTH + 4;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  // Configuration registers
  logic [KERNEL_W-1:0] kernel_q;
  logic [IMG_W_W-1:0]  width_q;
  logic [IMG_H_W-1:0]  height_q;
  logic                cfg_wr, restart_cfg;

  // Frame geometry
  logic [XW-1:0] used_w;
  logic [YW-1:0] used_h;
  logic [LW-1:0] total;
  logic [LW:0]   need;

  // Positions
  logic [LW-1:0] icount_q, oidx_q, icount_nx;
  logic [XW-1:0] out_col_q;
  logic [YW-1:0] out_row_q;
  logic [AW-1:0] wr_ptr_q, op_ptr_q;

  // Control
  state_e        state_q, state_d;
  logic          in_acc, out_acc, pix_wr, ready_nx, last_q;
  logic [TAP_W-1:0] tap_q;
  logic          div_go_q;

  // Tap read
  logic [1:0]      trow, tcol;
  logic [WT_W-1:0] twt;
  logic            tval;
  logic [AW+1:0]   a_row, a_col, a_red1, a_red2;
  logic [AW-1:0]   raddr;
  logic [PIX_W-1:0] rdata;
  logic            tv_q;
  logic [WT_W-1:0] twt_q;

  // Accumulators and dividers
  logic [SUM_W-1:0]  sr_q, sg_q, sb_q;
  logic [WSUM_W-1:0] ws_q;
  logic              dr, dg, db;
  logic [CH_W-1:0]   qr, qg, qb;

  // Output register
  logic            ov_q;
  logic [CH_W-1:0] or_q, og_q, ob_q;
  logic            nw_q, fe_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign restart_cfg = cfg_wr && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT);

  // Clamp frame size to the supported range
  always_comb begin
    if (width_q == '0) begin
      used_w = XW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      used_w = XW'(MAX_WIDTH);
    end else begin
      used_w = XW'(width_q);
    end
    if (height_q == '0) begin
      used_h = YW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      used_h = YW'(MAX_HEIGHT);
    end else begin
      used_h = YW'(height_q);
    end
  end

  assign total = LW'(used_w) * LW'(used_h);

  // Readiness of the next output after this item
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_acc   = out_valid_o && out_ready_i;
  assign pix_wr    = in_acc && !command_i && (icount_q < total);
  assign icount_nx = icount_q + LW'(pix_wr);

  always_comb begin
    need = (LW + 1)'(oidx_q) + (LW + 1)'(used_w) + (LW + 1)'(1);
    if (need > (LW + 1)'(total - LW'(1))) begin
      need = (LW + 1)'(total - LW'(1));
    end
  end

  assign ready_nx = (oidx_q < icount_nx) && ((LW + 1)'(icount_nx) > need);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && ready_nx) state_d = ST_READ;
      ST_READ: if (tap_q == TAP_DONE) state_d = ST_DIV;
      ST_DIV:  if (dr && dg && db) state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Weight, position and memory address of the current tap
  always_comb begin
    trow = tap_row(tap_q);
    tcol = tap_col(tap_q);
    twt  = (tap_q > TAP_LAST) ? '0 : WT_W'(kernel_q >> {tap_q, 2'b00});
    tval = (twt != '0) && (tap_q <= TAP_LAST)
        && (trow != POS_BEFORE || out_row_q != '0)
        && (trow != POS_AFTER  || (out_row_q + YW'(1)) < used_h)
        && (tcol != POS_BEFORE || out_col_q != '0)
        && (tcol != POS_AFTER  || (out_col_q + XW'(1)) < used_w);
    case (trow)
      POS_BEFORE: a_row = (AW + 2)'(op_ptr_q) + (AW + 2)'(DEPTH) - (AW + 2)'(used_w);
      POS_AFTER:  a_row = (AW + 2)'(op_ptr_q) + (AW + 2)'(used_w);
      default:    a_row = (AW + 2)'(op_ptr_q);
    endcase
    case (tcol)
      POS_BEFORE: a_col = a_row + (AW + 2)'(DEPTH - 1);
      POS_AFTER:  a_col = a_row + (AW + 2)'(1);
      default:    a_col = a_row;
    endcase
    a_red1 = (a_col >= (AW + 2)'(DEPTH)) ? a_col - (AW + 2)'(DEPTH) : a_col;
    a_red2 = (a_red1 >= (AW + 2)'(DEPTH)) ? a_red1 - (AW + 2)'(DEPTH) : a_red1;
    raddr  = a_red2[AW-1:0];
  end

  w3rc_linebuf #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_linebuf (
    .clk_i   (clk_i),
    .we_i    (pix_wr),
    .waddr_i (wr_ptr_q),
    .wdata_i ({pixel_red_i, pixel_green_i, pixel_blue_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  w3rc_div u_div_r (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_go_q),
    .dividend_i (sr_q), .divisor_i (ws_q), .done_o (dr), .quot_o (qr)
  );

  w3rc_div u_div_g (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_go_q),
    .dividend_i (sg_q), .divisor_i (ws_q), .done_o (dg), .quot_o (qg)
  );

  w3rc_div u_div_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_go_q),
    .dividend_i (sb_q), .divisor_i (ws_q), .done_o (db), .quot_o (qb)
  );

  // Control state, configuration and positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kernel_q  <= KERNEL_RST;
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
      icount_q  <= '0;
      oidx_q    <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      wr_ptr_q  <= '0;
      op_ptr_q  <= '0;
      tap_q     <= '0;
      div_go_q  <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_go_q <= (state_q == ST_READ) && (tap_q == TAP_DONE);
      // take configuration writes
      if (cfg_wr) begin
        case (cfg_index_i)
          CFG_KERNEL: kernel_q <= cfg_data_i;
          CFG_WIDTH:  width_q  <= cfg_data_i[IMG_W_W-1:0];
          CFG_HEIGHT: height_q <= cfg_data_i[IMG_H_W-1:0];
          default:    ;
        endcase
      end
      // advance input position
      if (pix_wr) begin
        icount_q <= icount_nx;
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      // step through the taps
      if (state_q == ST_IDLE) begin
        tap_q <= '0;
      end else if (state_q == ST_READ) begin
        tap_q <= tap_q + TAP_W'(1);
      end
      // hold result until taken
      if (state_q == ST_DIV && dr && dg && db) begin
        ov_q <= 1'b1;
      end else if (out_acc) begin
        ov_q <= 1'b0;
      end
      // advance output position, or restart at frame end
      if (restart_cfg || (out_acc && last_q)) begin
        icount_q  <= '0;
        oidx_q    <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        wr_ptr_q  <= '0;
        op_ptr_q  <= '0;
      end else if (out_acc) begin
        oidx_q   <= oidx_q + LW'(1);
        op_ptr_q <= (op_ptr_q == AW'(DEPTH - 1)) ? '0 : op_ptr_q + AW'(1);
        if ((out_col_q + XW'(1)) >= used_w) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + YW'(1);
        end else begin
          out_col_q <= out_col_q + XW'(1);
        end
      end
    end
  end

  // Accumulate taps and latch results
  always_ff @(posedge clk_i) begin
    tv_q  <= tval && (state_q == ST_READ);
    twt_q <= twt;
    if (in_acc) begin
      sr_q   <= '0;
      sg_q   <= '0;
      sb_q   <= '0;
      ws_q   <= '0;
      last_q <= (oidx_q == total - LW'(1));
    end else if (state_q == ST_READ && tv_q) begin
      sr_q <= sr_q + SUM_W'(rdata[3*CH_W-1:2*CH_W]) * SUM_W'(twt_q);
      sg_q <= sg_q + SUM_W'(rdata[2*CH_W-1:CH_W]) * SUM_W'(twt_q);
      sb_q <= sb_q + SUM_W'(rdata[CH_W-1:0]) * SUM_W'(twt_q);
      ws_q <= ws_q + WSUM_W'(twt_q);
    end
    if (state_q == ST_DIV && dr && dg && db) begin
      nw_q <= (ws_q == '0);
      fe_q <= last_q;
      or_q <= (ws_q == '0) ? '0 : qr;
      og_q <= (ws_q == '0) ? '0 : qg;
      ob_q <= (ws_q == '0) ? '0 : qb;
    end
  end

  assign out_valid_o = ov_q;
  assign out_red_o   = or_q;
  assign out_green_o = og_q;
  assign out_blue_o  = ob_q;
  assign no_weight_o = nw_q;
  assign frame_end_o = fe_q;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while a result is pending");

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (tap_q <= TAP_DONE))
    else $error("tap counter out of range");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q < AW'(DEPTH)) && (op_ptr_q < AW'(DEPTH)))
    else $error("history pointer beyond memory");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && frame_end_o) |=> (oidx_q == '0 && icount_q == '0))
    else $error("positions not cleared at frame end");
`endif

endmodule
